### src/mlfd_pkg.sv
package mlfd_pkg;

  localparam int MAX_MARK_BYTES = 4;
  localparam int MARK_LIMIT = (MAX_MARK_BYTES < 4) ? MAX_MARK_BYTES : 4;

  localparam logic [2:0] REG_HEAD_PATTERN     = 3'd0;
  localparam logic [2:0] REG_HEAD_PATTERN_LEN = 3'd1;
  localparam logic [2:0] REG_TAIL_PATTERN     = 3'd2;
  localparam logic [2:0] REG_TAIL_PATTERN_LEN = 3'd3;
  localparam logic [2:0] REG_MAX_FRAME_LEN    = 3'd4;
  localparam logic [2:0] REG_LENGTH_WIDTH     = 3'd5;
  localparam logic [2:0] REG_LENGTH_POS       = 3'd6;
  localparam logic [2:0] REG_LENGTH_ADJUST    = 3'd7;

  localparam logic [1:0] LW_ONE_BYTE  = 2'd0;
  localparam logic [1:0] LW_TWO_BYTES = 2'd1;

  typedef enum logic [2:0] {
    EV_HEAD_MATCH    = 3'd0,
    EV_BODY          = 3'd1,
    EV_HEAD_MISMATCH = 3'd2,
    EV_TOO_LONG      = 3'd3,
    EV_FRAME_ERROR   = 3'd4,
    EV_FRAME_DONE    = 3'd5
  } event_t;

  typedef struct packed {
    logic [31:0] head_pattern;
    logic [2:0]  head_pattern_len;
    logic [31:0] tail_pattern;
    logic [2:0]  tail_pattern_len;
    logic [15:0] max_frame_len;
    logic [1:0]  length_width;
    logic [7:0]  length_pos;
    logic [15:0] length_adjust;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [15:0] frame_position;
    event_t      ev;
    logic [15:0] frame_length;
  } res_t;

  function automatic logic [2:0] clip_mark_len(input logic [2:0] len);
    return (len > 3'(MARK_LIMIT)) ? 3'(MARK_LIMIT) : len;
  endfunction

endpackage

### src/marked_length_frame_deframer.sv
// Frame parser for a byte stream with a head mark, a little-endian length field
// of one, two or four bytes and a tail mark. Every received byte gives one
// result transaction carrying the byte, its position in the frame and an event
// code; frame_length is non-zero only with the frame complete event. The block
// takes one byte per clock cycle unless stalled; each result is registered:
// an accepted byte sits in the input register while a single pass through the
// frame logic works on it, and the result register takes the outcome when the
// byte advances. A waiting result does not stop the next byte from entering an
// empty input register; the input stalls only while both registers hold a
// transaction and the result is not taken. The user must write configuration
// only while no transaction is in flight; the block itself does not enforce this.
module marked_length_frame_deframer
  import mlfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  data_byte,
  output logic [15:0] frame_position,
  output logic [2:0]  event_res,
  output logic [15:0] frame_length
);

  cfg_t       cfg;
  logic       advance;
  logic       held_valid;
  logic [7:0] held_byte;
  res_t       step_res;
  res_t       res_r;
  logic       out_valid_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.head_pattern     <= 32'd0;
      cfg.head_pattern_len <= 3'd0;
      cfg.tail_pattern     <= 32'd0;
      cfg.tail_pattern_len <= 3'd0;
      cfg.max_frame_len    <= 16'hFFFF;
      cfg.length_width     <= 2'd0;
      cfg.length_pos       <= 8'd0;
      cfg.length_adjust    <= 16'd0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_HEAD_PATTERN:     cfg.head_pattern     <= cfg_data;
        REG_HEAD_PATTERN_LEN: cfg.head_pattern_len <= cfg_data[2:0];
        REG_TAIL_PATTERN:     cfg.tail_pattern     <= cfg_data;
        REG_TAIL_PATTERN_LEN: cfg.tail_pattern_len <= cfg_data[2:0];
        REG_MAX_FRAME_LEN:    cfg.max_frame_len    <= cfg_data[15:0];
        REG_LENGTH_WIDTH:     cfg.length_width     <= cfg_data[1:0];
        REG_LENGTH_POS:       cfg.length_pos       <= cfg_data[7:0];
        REG_LENGTH_ADJUST:    cfg.length_adjust    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign advance = held_valid && (!out_valid_r || out_ready);

  mlfd_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .advance    (advance),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  mlfd_core u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .step    (advance),
    .byte_in (held_byte),
    .res     (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= step_res;
    end
  end

  assign out_valid      = out_valid_r;
  assign data_byte      = res_r.data_byte;
  assign frame_position = res_r.frame_position;
  assign event_res      = res_r.ev;
  assign frame_length   = res_r.frame_length;

endmodule

### src/mlfd_in_stage.sv
module mlfd_in_stage
  import mlfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       advance,
  output logic       held_valid,
  output logic [7:0] held_byte
);

  logic       valid_r;
  logic [7:0] byte_r;

  assign in_ready   = !valid_r || advance;
  assign held_valid = valid_r;
  assign held_byte  = byte_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (advance) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= rx_byte;
    end
  end

endmodule

### src/mlfd_core.sv
module mlfd_core
  import mlfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       step,
  input  logic [7:0] byte_in,
  output res_t       res
);

  logic [15:0] position;
  logic [31:0] length_bytes;
  logic [31:0] tail_window;
  logic [15:0] position_next;
  logic [31:0] length_bytes_next;
  logic [31:0] tail_window_next;

  logic [2:0]  hlen;
  logic [2:0]  tlen;
  logic [2:0]  nbytes;
  logic        in_head;
  logic [7:0]  head_byte;
  logic [16:0] field_start;
  logic [16:0] field_end;
  logic        in_field;
  logic [1:0]  field_k;
  logic [15:0] pos_inc;
  logic [31:0] len_stored;
  logic [31:0] tail_stored;
  logic        field_done;
  logic [32:0] total;
  logic        too_long;
  logic        tail_ok;
  logic        restart;
  event_t      ev;
  logic [15:0] flen;

  always_comb begin
    case (cfg.length_width)
      LW_ONE_BYTE:  nbytes = 3'd1;
      LW_TWO_BYTES: nbytes = 3'd2;
      default:      nbytes = 3'd4;
    endcase
  end

  assign hlen        = clip_mark_len(cfg.head_pattern_len);
  assign tlen        = clip_mark_len(cfg.tail_pattern_len);
  assign in_head     = position < 16'(hlen);
  assign head_byte   = cfg.head_pattern[{position[1:0], 3'b000} +: 8];
  assign field_start = {9'b0, cfg.length_pos};
  assign field_end   = field_start + {14'b0, nbytes};
  assign in_field    = ({1'b0, position} >= field_start) && ({1'b0, position} < field_end);
  assign field_k     = position[1:0] - cfg.length_pos[1:0];
  assign pos_inc     = position + 16'd1;
  assign len_stored  = in_field ? (length_bytes | ({24'b0, byte_in} << {field_k, 3'b000}))
                                : length_bytes;
  assign tail_stored = {tail_window[23:0], byte_in};
  assign field_done  = {1'b0, pos_inc} >= field_end;
  assign total       = {1'b0, len_stored} + {17'b0, cfg.length_adjust};
  assign too_long    = total > {17'b0, cfg.max_frame_len};

  always_comb begin
    logic [2:0] j;
    tail_ok = pos_inc >= 16'(tlen);
    for (int i = 0; i < 4; i++) begin
      j = tlen - 3'd1 - 3'(i);
      if (3'(i) < tlen &&
          cfg.tail_pattern[8*i +: 8] != tail_stored[{j[1:0], 3'b000} +: 8]) begin
        tail_ok = 1'b0;
      end
    end
  end

  always_comb begin
    restart = 1'b0;
    flen    = 16'd0;
    if (in_head) begin
      if (head_byte == byte_in) begin
        ev = EV_HEAD_MATCH;
      end else begin
        ev      = EV_HEAD_MISMATCH;
        restart = 1'b1;
      end
    end else begin
      ev = EV_BODY;
      if (field_done) begin
        if (too_long) begin
          ev      = EV_TOO_LONG;
          restart = 1'b1;
        end else if ({17'b0, pos_inc} == total && tail_ok) begin
          ev      = EV_FRAME_DONE;
          flen    = total[15:0];
          restart = 1'b1;
        end else if ({17'b0, pos_inc} >= total) begin
          ev      = EV_FRAME_ERROR;
          restart = 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (restart) begin
      position_next     = 16'd0;
      length_bytes_next = 32'd0;
      tail_window_next  = 32'd0;
    end else begin
      position_next     = pos_inc;
      length_bytes_next = len_stored;
      tail_window_next  = tail_stored;
    end
  end

  assign res.data_byte      = byte_in;
  assign res.frame_position = position;
  assign res.ev             = ev;
  assign res.frame_length   = flen;

  always_ff @(posedge clk) begin
    if (rst) begin
      position     <= 16'd0;
      length_bytes <= 32'd0;
      tail_window  <= 32'd0;
    end else if (step) begin
      position     <= position_next;
      length_bytes <= length_bytes_next;
      tail_window  <= tail_window_next;
    end
  end

endmodule

### src/mlfd_checker.sv
module mlfd_checker
  import mlfd_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  data_byte,
  input logic [15:0] frame_position,
  input logic [2:0]  event_res,
  input logic [15:0] frame_length
);

  // A stalled result must be held unchanged until it is taken.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(data_byte) &&
      $stable(frame_position) && $stable(event_res) && $stable(frame_length))
    else $error("stalled result transaction changed");

  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid straight after reset");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && event_res != EV_FRAME_DONE |-> frame_length == 16'd0)
    else $error("frame length reported without frame completion");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && event_res == EV_FRAME_DONE |-> frame_length == frame_position + 16'd1)
    else $error("completed frame length does not follow its last position");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_res == EV_HEAD_MATCH || event_res == EV_HEAD_MISMATCH) |->
      frame_position < 16'(MARK_LIMIT))
    else $error("head event beyond the head mark");

endmodule

bind marked_length_frame_deframer mlfd_checker u_mlfd_checker (.*);

### verif/marked_length_frame_deframer_tb.sv
`timescale 1ns / 100ps

module marked_length_frame_deframer_tb;
  import mlfd_pkg::*;

  localparam logic [1:0] LW_FOUR_BYTES = 2'd2;
  localparam logic [1:0] LW_WIDE_CODE  = 2'd3;
  localparam int RANDOM_BYTES = 1700;
  localparam int PHASE_BYTES  = 180;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_write;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  data_byte;
  logic [15:0] frame_position;
  logic [2:0]  event_res;
  logic [15:0] frame_length;

  // Register copy and frame tracking state used to predict each result.
  cfg_t        setup;
  logic [15:0] frame_pos;
  logic [31:0] len_field;
  logic [31:0] tail_win;
  res_t        expected_res[$];

  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  int rx_hold = 0;
  int faults = 0;
  int sent_bytes = 0;

  marked_length_frame_deframer u_dut (.*);

  always #4 clk = ~clk;

  function automatic int mark_bytes(input logic [2:0] len);
    return (int'(len) > MARK_LIMIT) ? MARK_LIMIT : int'(len);
  endfunction

  function automatic int field_bytes(input logic [1:0] code);
    case (code)
      LW_ONE_BYTE: return 1;
      LW_TWO_BYTES: return 2;
      default: return 4;
    endcase
  endfunction

  function automatic void clear_frame();
    frame_pos = '0;
    len_field = '0;
    tail_win = '0;
  endfunction

  function automatic void keep_byte(input logic [7:0] b, input int nb);
    int k;
    k = int'(frame_pos) - int'(setup.length_pos);
    if (k >= 0 && k < nb) len_field = len_field | (32'(b) << (8 * k));
    tail_win = {tail_win[23:0], b};
    frame_pos = frame_pos + 16'd1;
  endfunction

  function automatic bit tail_ok();
    int t;
    t = mark_bytes(setup.tail_pattern_len);
    if (int'(frame_pos) < t) return 1'b0;
    for (int i = 0; i < t; i++) begin
      if (setup.tail_pattern[8*i +: 8] != tail_win[8*(t-1-i) +: 8]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Works out the result of one accepted byte and queues it.
  function automatic void advance_frame(input logic [7:0] b);
    res_t        r;
    int          nb;
    logic [63:0] total;
    nb = field_bytes(setup.length_width);
    r.data_byte = b;
    r.frame_position = frame_pos;
    r.frame_length = '0;
    if (int'(frame_pos) < mark_bytes(setup.head_pattern_len)) begin
      if (setup.head_pattern[8*frame_pos +: 8] == b) begin
        keep_byte(b, nb);
        r.ev = EV_HEAD_MATCH;
      end else begin
        clear_frame();
        r.ev = EV_HEAD_MISMATCH;
      end
    end else begin
      keep_byte(b, nb);
      r.ev = EV_BODY;
      if (int'(frame_pos) >= int'(setup.length_pos) + nb) begin
        total = {32'd0, len_field} + 64'(setup.length_adjust);
        if (total > 64'(setup.max_frame_len)) begin
          clear_frame();
          r.ev = EV_TOO_LONG;
        end else if (64'(frame_pos) == total && tail_ok()) begin
          r.frame_length = total[15:0];
          clear_frame();
          r.ev = EV_FRAME_DONE;
        end else if (64'(frame_pos) >= total) begin
          clear_frame();
          r.ev = EV_FRAME_ERROR;
        end
      end
    end
    expected_res.push_back(r);
  endfunction

  function automatic void note_fault(input string msg);
    faults++;
    if (faults <= 10) $display("%s", msg);
  endfunction

  always @(posedge clk) begin : check_results
    res_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_res.size() == 0) begin
        note_fault($sformatf("%0t: unexpected result byte %02h pos %0d event %0d length %0d",
                             $time, data_byte, frame_position, event_res, frame_length));
      end else begin
        want = expected_res.pop_front();
        if (data_byte !== want.data_byte || frame_position !== want.frame_position ||
            event_res !== want.ev || frame_length !== want.frame_length) begin
          note_fault($sformatf({"%0t: mismatch, expected byte %02h pos %0d event %0d length %0d,",
                                " got byte %02h pos %0d event %0d length %0d"},
                               $time, want.data_byte, want.frame_position, want.ev,
                               want.frame_length, data_byte, frame_position, event_res,
                               frame_length));
        end
      end
    end
  end

  // While rx_idle is set, the receiver waits a drawn number of cycles before each
  // transaction, or a long hold-off when one is requested.
  initial begin : receiver
    int stall;
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      stall = rx_idle ? $urandom_range(0, 8) : 0;
      if (rx_hold > 0) begin
        stall = rx_hold;
        rx_hold = 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = tx_idle ? $urandom_range(0, 8) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    advance_frame(b);
    sent_bytes++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_res.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_HEAD_PATTERN: setup.head_pattern = val;
      REG_HEAD_PATTERN_LEN: setup.head_pattern_len = val[2:0];
      REG_TAIL_PATTERN: setup.tail_pattern = val;
      REG_TAIL_PATTERN_LEN: setup.tail_pattern_len = val[2:0];
      REG_MAX_FRAME_LEN: setup.max_frame_len = val[15:0];
      REG_LENGTH_WIDTH: setup.length_width = val[1:0];
      REG_LENGTH_POS: setup.length_pos = val[7:0];
      REG_LENGTH_ADJUST: setup.length_adjust = val[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic apply_setup(input cfg_t c);
    write_reg(REG_HEAD_PATTERN, c.head_pattern);
    write_reg(REG_HEAD_PATTERN_LEN, 32'(c.head_pattern_len));
    write_reg(REG_TAIL_PATTERN, c.tail_pattern);
    write_reg(REG_TAIL_PATTERN_LEN, 32'(c.tail_pattern_len));
    write_reg(REG_MAX_FRAME_LEN, 32'(c.max_frame_len));
    write_reg(REG_LENGTH_WIDTH, 32'(c.length_width));
    write_reg(REG_LENGTH_POS, 32'(c.length_pos));
    write_reg(REG_LENGTH_ADJUST, 32'(c.length_adjust));
  endtask

  // Sends filler bytes until the frame in progress has ended.
  task automatic finish_frame();
    while (frame_pos != 0) begin
      if (int'(frame_pos) < mark_bytes(setup.head_pattern_len))
        send_byte(~setup.head_pattern[8*frame_pos +: 8]);
      else
        send_byte(8'($urandom));
    end
  endtask

  // Builds one frame for the current registers. A broken frame carries a length
  // value moved by one to three or a corrupted byte outside the length field.
  task automatic send_frame(input bit well_formed);
    logic [7:0] frame_bytes[$];
    int hb, tb, nb, lpos, flen, fld_val, noise, d, p;
    finish_frame();
    hb = mark_bytes(setup.head_pattern_len);
    tb = mark_bytes(setup.tail_pattern_len);
    nb = field_bytes(setup.length_width);
    lpos = int'(setup.length_pos);
    flen = ((hb > lpos + nb) ? hb : lpos + nb) + tb + $urandom_range(0, 12);
    fld_val = flen - int'(setup.length_adjust);
    noise = well_formed ? 0 : $urandom_range(1, 3);
    d = $urandom_range(1, 3);
    if (noise == 1) fld_val += d;
    if (noise == 2 && fld_val >= d) fld_val -= d;
    repeat (flen) frame_bytes.push_back(8'($urandom));
    for (int i = 0; i < tb; i++) frame_bytes[flen - tb + i] = setup.tail_pattern[8*i +: 8];
    for (int k = 0; k < nb; k++) begin
      if (lpos + k < flen) frame_bytes[lpos + k] = fld_val[8*k +: 8];
    end
    for (int i = 0; i < hb; i++) frame_bytes[i] = setup.head_pattern[8*i +: 8];
    if (noise == 3) begin
      p = $urandom_range(0, flen - 1);
      if (p < lpos || p >= lpos + nb) frame_bytes[p] ^= 8'(1 << $urandom_range(0, 7));
    end
    foreach (frame_bytes[i]) begin
      send_byte(frame_bytes[i]);
      if (frame_pos == 0) break;
    end
  endtask

  function automatic cfg_t pick_setup(input int phase);
    cfg_t c;
    int hb, nb, lmin;
    c.head_pattern = $urandom;
    c.tail_pattern = $urandom;
    c.head_pattern_len = 3'(($urandom_range(0, 5) == 0) ? $urandom_range(5, 7)
                                                        : $urandom_range(0, 4));
    c.tail_pattern_len = 3'(($urandom_range(0, 5) == 0) ? $urandom_range(5, 7)
                                                        : $urandom_range(0, 4));
    c.length_width = 2'($urandom_range(0, 3));
    hb = mark_bytes(c.head_pattern_len);
    nb = field_bytes(c.length_width);
    c.length_pos = 8'(($urandom_range(0, 7) == 0) ? hb + $urandom_range(0, 255 - hb)
                                                  : hb + $urandom_range(0, 3));
    lmin = ((hb > int'(c.length_pos) + nb) ? hb : int'(c.length_pos) + nb) +
           mark_bytes(c.tail_pattern_len);
    c.length_adjust = 16'($urandom_range(0, lmin));
    case ($urandom_range(0, 3))
      0: c.max_frame_len = 16'hFFFF;
      3: c.max_frame_len = 16'($urandom_range(0, lmin + 12));
      default: c.max_frame_len = 16'(lmin + $urandom_range(0, 16));
    endcase
    if (phase == 0) c = '0;
    if (phase == 1) begin
      c.head_pattern = '1;
      c.head_pattern_len = 3'd4;
      c.tail_pattern = '1;
      c.tail_pattern_len = 3'd4;
      c.max_frame_len = 16'hFFFF;
      c.length_width = LW_FOUR_BYTES;
      c.length_pos = 8'hFF;
      c.length_adjust = '0;
    end
    return c;
  endfunction

  task automatic test_reset_values();
    send_byte(8'h01);
    send_byte(8'h00);
    send_byte(8'h02);
    send_byte(8'hFF);
    wait_drained();
  endtask

  task automatic test_marks_and_wide_length();
    write_reg(REG_HEAD_PATTERN, 32'h3CC35AA5);
    write_reg(REG_HEAD_PATTERN_LEN, 32'd7);
    write_reg(REG_TAIL_PATTERN, 32'hFF0000FF);
    write_reg(REG_TAIL_PATTERN_LEN, 32'd5);
    write_reg(REG_LENGTH_WIDTH, 32'(LW_WIDE_CODE));
    write_reg(REG_LENGTH_POS, 32'd4);
    for (int i = 0; i < 4; i++) send_byte(setup.head_pattern[8*i +: 8]);
    send_byte(8'h0C);
    repeat (3) send_byte(8'h00);
    for (int i = 0; i < 4; i++) send_byte(setup.tail_pattern[8*i +: 8]);
    // A mismatching byte restarts the frame and is not taken as a new first head byte.
    send_byte(8'hA5);
    send_byte(8'hA5);
    send_byte(8'h5A);
    wait_drained();
  endtask

  task automatic test_length_overflow();
    write_reg(REG_HEAD_PATTERN_LEN, 32'd0);
    write_reg(REG_LENGTH_POS, 32'd0);
    write_reg(REG_LENGTH_WIDTH, 32'(LW_FOUR_BYTES));
    write_reg(REG_MAX_FRAME_LEN, 32'hFFFF);
    write_reg(REG_LENGTH_ADJUST, 32'hFFFF);
    repeat (4) send_byte(8'hFF);
    wait_drained();
  endtask

  task automatic test_short_frame();
    write_reg(REG_LENGTH_WIDTH, 32'(LW_ONE_BYTE));
    write_reg(REG_LENGTH_ADJUST, 32'd0);
    send_byte(8'h02);
    send_byte(8'h00);
    wait_drained();
  endtask

  task automatic test_backpressure();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    rx_hold = 48;
    repeat (3) send_frame(1'b1);
    wait_drained();
  endtask

  task automatic test_random_frames();
    cfg_t c;
    int phase, goal, phase_end;
    phase = 0;
    goal = sent_bytes + RANDOM_BYTES;
    while (sent_bytes < goal) begin
      c = pick_setup(phase);
      finish_frame();
      wait_drained();
      apply_setup(c);
      phase_end = sent_bytes + PHASE_BYTES;
      while (sent_bytes < phase_end) begin
        tx_idle = ($urandom_range(0, 3) != 0);
        rx_idle = ($urandom_range(0, 3) != 0);
        send_frame($urandom_range(0, 3) != 0);
      end
      phase++;
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    rx_byte = '0;
    cfg_write = 1'b0;
    cfg_index = REG_HEAD_PATTERN;
    cfg_data = '0;
    setup = '0;
    setup.max_frame_len = 16'hFFFF;
    clear_frame();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_values();
    test_marks_and_wide_length();
    test_length_overflow();
    test_short_frame();
    test_backpressure();
    test_random_frames();
    wait_drained();
    repeat (8) @(negedge clk);
    if (faults == 0 && expected_res.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

endmodule
